### rtl/assert_macros.svh
// Assertion macros for the access list table RTL.
// No dependencies; included by alt_back, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ALT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ALT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/alt_pkg.sv
// Package for the access list table: sizes, operation codes, payload types.
// No dependencies; used by every module of the block but alt_ram.
package alt_pkg;

    localparam int TABLE_ENTRIES = 512;
    localparam int ADDR_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_ENTRIES - 1);

    localparam int ID_W    = 56;
    localparam int RELAY_W = 8;
    localparam int FUNC_W  = 3;

    // func codes on the input channel
    localparam logic [FUNC_W-1:0] FUNC_AUTH   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_GET    = 3'd4;

    localparam logic [RELAY_W-1:0] RELAY_FIRST  = 8'd1;
    localparam logic [RELAY_W-1:0] RELAY_SECOND = 8'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [ID_W-1:0]    card_id;
        logic [RELAY_W-1:0] relay_select;
        logic               allow_first;
        logic               allow_second;
    } t_in;

    typedef struct packed {
        logic ok;
        logic first_bit;
        logic second_bit;
    } t_out;

    // Decoded operation; OP_NONE covers unused codes and a zero card id on any operation but clear.
    typedef enum logic [2:0] {
        OP_AUTH,
        OP_ADD,
        OP_REMOVE,
        OP_CLEAR,
        OP_GET,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [ID_W-1:0]    card_id;
        logic [RELAY_W-1:0] relay_select;
        logic               allow_first;
        logic               allow_second;
    } t_cmd;

    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] card_id;
        logic            perm_first;
        logic            perm_second;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLEAR,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

### rtl/access_list_table_top.sv
// Top level of the access list table: card ids with two relay permission bits.
// Depends on alt_pkg, alt_front and alt_back.
//
// Input channel: i_in_valid / o_in_stall / i_in_data carries one operation
// (authorize, add, remove, clear all, get entry). A transfer takes place on a
// clock edge with valid high and stall low. Up to two operations queue in
// front of the table engine, so inputs keep flowing while a result waits.
// Output channel: o_out_valid / i_out_stall / o_out_data carries exactly one
// result per operation, in order. A stalled result holds until transferred.
// A lookup operation reads every table slot once through the single RAM read
// port; clear all writes one slot per cycle; a non-clear operation with a zero
// card id, or an unused func code, answers without touching the table.
// The engine takes one operation at a time; the next leaves the queue only
// once the engine is back in idle after the previous result.
// Reset (i_rst_n low, synchronous) empties the queue and starts a clearing
// pass over every slot of the table RAM; queued operations wait until it
// ends. A receiver that stalls holds the engine once its result register and
// the done state are both occupied; the queue then fills and o_in_stall rises.
module access_list_table_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  alt_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output alt_pkg::t_out o_out_data
);
    import alt_pkg::*;

    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    alt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_q_valid  (q_valid),
        .o_q_cmd    (q_cmd),
        .i_pop      (q_pop)
    );

    alt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

### rtl/alt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module alt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/alt_front.sv
// Front end: accepts operations, decodes them and queues them for the back end.
// Depends on alt_pkg.
module alt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  alt_pkg::t_in  i_in_data,
    output logic          o_q_valid,
    output alt_pkg::t_cmd o_q_cmd,
    input  logic          i_pop
);
    import alt_pkg::*;

    t_cmd       dec_cmd;
    t_cmd       r_mem [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       push;

    always_comb begin
        dec_cmd.card_id      = i_in_data.card_id;
        dec_cmd.relay_select = i_in_data.relay_select;
        dec_cmd.allow_first  = i_in_data.allow_first;
        dec_cmd.allow_second = i_in_data.allow_second;
        case (i_in_data.func)
            FUNC_AUTH:   dec_cmd.op = OP_AUTH;
            FUNC_ADD:    dec_cmd.op = OP_ADD;
            FUNC_REMOVE: dec_cmd.op = OP_REMOVE;
            FUNC_CLEAR:  dec_cmd.op = OP_CLEAR;
            FUNC_GET:    dec_cmd.op = OP_GET;
            default:     dec_cmd.op = OP_NONE;
        endcase
        // zero id is rejected by every lookup operation
        if (i_in_data.card_id == '0 && dec_cmd.op != OP_CLEAR) begin
            dec_cmd.op = OP_NONE;
        end
    end

    assign o_in_stall = (r_cnt == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_cmd    = r_mem[r_rp];

    always_comb begin
        n_wp  = push  ? ~r_wp : r_wp;
        n_rp  = i_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= dec_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

### rtl/alt_back.sv
// Back end: scans the table RAM per lookup, clears or updates it, drives the result register.
// Depends on alt_pkg, alt_ram and assert_macros.svh.
`include "assert_macros.svh"
module alt_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  alt_pkg::t_cmd i_q_cmd,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output alt_pkg::t_out o_out_data
);
    import alt_pkg::*;

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              r_issued, n_issued;
    logic              r_chk, n_chk;
    logic [ADDR_W-1:0] r_chk_addr, n_chk_addr;
    logic              r_hit, n_hit;
    logic [ADDR_W-1:0] r_hit_addr, n_hit_addr;
    logic              r_hit_first, n_hit_first;
    logic              r_hit_second, n_hit_second;
    logic              r_free, n_free;
    logic [ADDR_W-1:0] r_free_addr, n_free_addr;
    logic              r_reply, n_reply;
    t_out              r_res, n_res;
    logic              r_out_valid, n_out_valid;
    t_out              r_out, n_out;

    logic              out_free;
    logic              ram_rd_en;
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    t_entry            ram_wr_data;
    logic [$bits(t_entry)-1:0] ram_q;
    t_entry            ram_rdata;

    alt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (ram_q)
    );

    assign ram_rdata = t_entry'(ram_q);
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_addr       = r_addr;
        n_issued     = r_issued;
        n_chk        = 1'b0;
        n_chk_addr   = r_chk_addr;
        n_hit        = r_hit;
        n_hit_addr   = r_hit_addr;
        n_hit_first  = r_hit_first;
        n_hit_second = r_hit_second;
        n_free       = r_free;
        n_free_addr  = r_free_addr;
        n_reply      = r_reply;
        n_res        = r_res;
        o_pop        = 1'b0;
        ram_rd_en    = 1'b0;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_addr;
        ram_wr_data  = '0;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop    = 1'b1;
                    n_cmd    = i_q_cmd;
                    n_addr   = '0;
                    n_issued = 1'b0;
                    n_hit    = 1'b0;
                    n_free   = 1'b0;
                    case (i_q_cmd.op)
                        OP_NONE: begin
                            n_res   = '0;
                            n_state = S_DONE;
                        end
                        OP_CLEAR: begin
                            n_reply = 1'b1;
                            n_state = S_CLEAR;
                        end
                        default: begin
                            n_state = S_SCAN;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                ram_wr_en = 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_addr = '0;
                    if (r_reply) begin
                        n_res   = '{ok: 1'b1, first_bit: 1'b0, second_bit: 1'b0};
                        n_state = S_DONE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_addr = r_addr + ADDR_W'(1);
                end
            end
            S_SCAN: begin
                // the compare handles each read in the cycle after its issue
                if (!r_issued) begin
                    ram_rd_en  = 1'b1;
                    n_chk      = 1'b1;
                    n_chk_addr = r_addr;
                    if (r_addr == LAST_ADDR) begin
                        n_issued = 1'b1;
                    end else begin
                        n_addr = r_addr + ADDR_W'(1);
                    end
                end
                if (r_chk) begin
                    if (ram_rdata.valid && ram_rdata.card_id == r_cmd.card_id && !r_hit) begin
                        n_hit        = 1'b1;
                        n_hit_addr   = r_chk_addr;
                        n_hit_first  = ram_rdata.perm_first;
                        n_hit_second = ram_rdata.perm_second;
                    end
                    if (!ram_rdata.valid && !r_free) begin
                        n_free      = 1'b1;
                        n_free_addr = r_chk_addr;
                    end
                end
                if (r_issued && !r_chk) begin
                    n_res   = '0;
                    n_state = S_DONE;
                    case (r_cmd.op)
                        OP_AUTH: begin
                            if (r_cmd.relay_select == RELAY_FIRST) begin
                                n_res.ok = r_hit && r_hit_first;
                            end else if (r_cmd.relay_select == RELAY_SECOND) begin
                                n_res.ok = r_hit && r_hit_second;
                            end
                        end
                        OP_GET: begin
                            n_res.ok         = r_hit;
                            n_res.first_bit  = r_hit && r_hit_first;
                            n_res.second_bit = r_hit && r_hit_second;
                        end
                        OP_REMOVE: begin
                            n_res.ok    = r_hit;
                            ram_wr_en   = r_hit;
                            ram_wr_addr = r_hit_addr;
                        end
                        OP_ADD: begin
                            n_res.ok                = !r_hit && r_free;
                            ram_wr_en               = !r_hit && r_free;
                            ram_wr_addr             = r_free_addr;
                            ram_wr_data.valid       = 1'b1;
                            ram_wr_data.card_id     = r_cmd.card_id;
                            ram_wr_data.perm_first  = r_cmd.allow_first;
                            ram_wr_data.perm_second = r_cmd.allow_second;
                        end
                        default: begin
                            n_res = '0;
                        end
                    endcase
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_state == S_DONE && out_free) begin
            n_out_valid = 1'b1;
            n_out       = r_res;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_issued    <= 1'b0;
            r_chk       <= 1'b0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_reply     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_issued    <= n_issued;
            r_chk       <= n_chk;
            r_hit       <= n_hit;
            r_free      <= n_free;
            r_reply     <= n_reply;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_chk_addr   <= n_chk_addr;
        r_hit_addr   <= n_hit_addr;
        r_hit_first  <= n_hit_first;
        r_hit_second <= n_hit_second;
        r_free_addr  <= n_free_addr;
        r_res        <= n_res;
        r_out        <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ALT_ASSERT(a_chk_follows_read, i_clk, i_rst_n, r_chk |-> $past(ram_rd_en), "compare without a read")
    `ALT_ASSERT(a_no_rw_same_cycle, i_clk, i_rst_n, !(ram_rd_en && ram_wr_en), "table read and write overlap")
    `ALT_ASSERT(a_wr_only_on_update, i_clk, i_rst_n, (ram_wr_en && r_state != S_CLEAR) |-> (r_cmd.op == OP_ADD || r_cmd.op == OP_REMOVE), "table write outside add or remove")
    `ALT_ASSERT(a_pop_leaves_idle, i_clk, i_rst_n, o_pop |=> r_state != S_IDLE, "popped operation not started")

endmodule

### tb/tb.sv
// Self-checking testbench for access_list_table_top: card lookup, add, remove,
// clear and get transfers, checked against typed-in results and a behavioral model of the table.
// Depends on alt_pkg and the access_list_table_top RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import alt_pkg::*;

    // func codes the block decodes as no operation
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO  = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_MID = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI  = 3'd7;

    // relay numbers that never grant
    localparam logic [RELAY_W-1:0] RELAY_ZERO = 8'd0;
    localparam logic [RELAY_W-1:0] RELAY_TOP  = 8'hFF;

    localparam logic [ID_W-1:0] ID_ZERO = '0;
    localparam logic [ID_W-1:0] ID_ONE  = 56'd1;
    localparam logic [ID_W-1:0] ID_MAX  = '1;
    localparam logic [ID_W-1:0] ID_MID  = 56'h5A_C3F0_0F3C_A5E1;

    localparam t_out RES_NONE   = 3'b000;
    localparam t_out RES_OK     = 3'b100;
    localparam t_out RES_FIRST  = 3'b110;

    localparam int POOL_SIZE    = 12;
    localparam int DRAIN_CYCLES = 600;

    typedef enum int {STALL_NONE, STALL_COIN, STALL_RUNS} t_stall_mode;

    typedef struct {
        t_in  op;
        bit   fixed;    // result typed in; otherwise taken from the table model
        t_out res;
    } t_dir_row;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    t_out out_data;

    // table model
    bit              acl_valid  [TABLE_ENTRIES];
    logic [ID_W-1:0] acl_id     [TABLE_ENTRIES];
    bit              acl_first  [TABLE_ENTRIES];
    bit              acl_second [TABLE_ENTRIES];
    int              acl_count;

    t_out            pending_results[$];
    t_dir_row        dir_rows[$];
    logic [ID_W-1:0] card_pool [POOL_SIZE];
    logic [ID_W-1:0] filled_ids[$];
    int              mismatches;
    int              results_seen;
    int              burst_left;

    t_stall_mode     stall_mode;
    int              stall_run;
    int              mode_left;

    access_list_table_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #2 clk = ~clk;

    initial begin
        #16_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic void empty_acl();
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            acl_valid[i]  = 1'b0;
            acl_id[i]     = '0;
            acl_first[i]  = 1'b0;
            acl_second[i] = 1'b0;
        end
        acl_count = 0;
    endfunction

    function automatic int find_card(logic [ID_W-1:0] id);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (acl_valid[i] && acl_id[i] == id) return i;
        end
        return -1;
    endfunction

    // Applies one operation to the table model and returns its result.
    function automatic t_out apply_card_op(t_in op);
        t_out r;
        int   slot;
        r = RES_NONE;
        slot = (op.card_id != ID_ZERO) ? find_card(op.card_id) : -1;
        case (op.func)
            FUNC_AUTH: begin
                if (slot >= 0) begin
                    if (op.relay_select == RELAY_FIRST) r.ok = acl_first[slot];
                    else if (op.relay_select == RELAY_SECOND) r.ok = acl_second[slot];
                end
            end
            FUNC_ADD: begin
                if (op.card_id != ID_ZERO && slot < 0) begin
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (!acl_valid[i]) begin
                            acl_valid[i]  = 1'b1;
                            acl_id[i]     = op.card_id;
                            acl_first[i]  = op.allow_first;
                            acl_second[i] = op.allow_second;
                            acl_count++;
                            r.ok = 1'b1;
                            break;
                        end
                    end
                end
            end
            FUNC_REMOVE: begin
                if (slot >= 0) begin
                    acl_valid[slot]  = 1'b0;
                    acl_id[slot]     = '0;
                    acl_first[slot]  = 1'b0;
                    acl_second[slot] = 1'b0;
                    acl_count--;
                    r.ok = 1'b1;
                end
            end
            FUNC_CLEAR: begin
                empty_acl();
                r.ok = 1'b1;
            end
            FUNC_GET: begin
                if (slot >= 0) begin
                    r.ok         = 1'b1;
                    r.first_bit  = acl_first[slot];
                    r.second_bit = acl_second[slot];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_in make_op(logic [FUNC_W-1:0] func, logic [ID_W-1:0] id,
                                    logic [RELAY_W-1:0] relay, logic a1, logic a2);
        t_in op;
        op.func         = func;
        op.card_id      = id;
        op.relay_select = relay;
        op.allow_first  = a1;
        op.allow_second = a2;
        return op;
    endfunction

    function automatic void add_row(t_in op, bit fixed, t_out res);
        t_dir_row row;
        row.op    = op;
        row.fixed = fixed;
        row.res   = res;
        dir_rows.push_back(row);
    endfunction

    function automatic logic [ID_W-1:0] rand_id();
        logic [63:0] r;
        do begin
            r = {$urandom(), $urandom()};
        end while (r[ID_W-1:0] == ID_ZERO);
        return r[ID_W-1:0];
    endfunction

    function automatic logic [RELAY_W-1:0] rand_relay();
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 1) ? RELAY_FIRST : RELAY_SECOND;
        return RELAY_W'($urandom_range(0, 255));
    endfunction

    function automatic t_in random_op();
        t_in op;
        int  pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)      op.func = FUNC_AUTH;
        else if (pick < 55) op.func = FUNC_ADD;
        else if (pick < 67) op.func = FUNC_REMOVE;
        else if (pick < 87) op.func = FUNC_GET;
        else if (pick < 90) op.func = FUNC_CLEAR;
        else op.func = FUNC_W'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
        pick = $urandom_range(0, 99);
        if (pick < 5)       op.card_id = ID_ZERO;
        else if (pick < 25) op.card_id = rand_id();
        else op.card_id = card_pool[$urandom_range(0, POOL_SIZE - 1)];
        op.relay_select = rand_relay();
        op.allow_first  = 1'($urandom_range(0, 1));
        op.allow_second = 1'($urandom_range(0, 1));
        return op;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch on result %0d: %s", $realtime, results_seen, msg);
        mismatches++;
    endtask

    // Drives one operation and holds it until the transfer; called at a clock edge.
    task automatic push_op(t_in op, bit fixed = 1'b0, t_out fixed_res = RES_NONE);
        t_out predicted;
        in_data  <= op;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predicted = apply_card_op(op);
        pending_results.push_back(fixed ? fixed_res : predicted);
    endtask

    // Sender bursts: mostly short gaps, sometimes long enough to let the engine drain.
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_valid <= 1'b0;
            if ($urandom_range(0, 5) == 0) repeat ($urandom_range(100, 600)) @(posedge clk);
            else repeat ($urandom_range(1, 20)) @(posedge clk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // Receiver stall pattern, switching mode every few result periods.
    always @(posedge clk) begin
        if (mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 2));
            mode_left  = $urandom_range(500, 3000);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            STALL_NONE: out_stall <= 1'b0;
            STALL_COIN: out_stall <= ($urandom_range(0, 1) == 1);
            default: begin
                if (stall_run == 0) begin
                    out_stall <= ~out_stall;
                    stall_run = $urandom_range(1, 40);
                end else begin
                    stall_run--;
                end
            end
        endcase
    end

    always @(posedge clk) begin
        t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %b with nothing pending", out_data));
            end else begin
                want = pending_results.pop_front();
                if (out_data.ok !== want.ok)
                    report_mismatch($sformatf("ok %b, want %b", out_data.ok, want.ok));
                if (out_data.first_bit !== want.first_bit)
                    report_mismatch($sformatf("first_bit %b, want %b",
                                              out_data.first_bit, want.first_bit));
                if (out_data.second_bit !== want.second_bit)
                    report_mismatch($sformatf("second_bit %b, want %b",
                                              out_data.second_bit, want.second_bit));
            end
            results_seen++;
        end
    end

    initial begin
        logic [ID_W-1:0] id;
        int              k;

        empty_acl();
        for (int i = 0; i < POOL_SIZE; i++) card_pool[i] = rand_id();

        // empty table first, then a few entries and refused operations
        add_row(make_op(FUNC_AUTH, ID_ONE, RELAY_FIRST, 1'b0, 1'b0), 1'b1, RES_NONE);
        add_row(make_op(FUNC_GET, ID_MAX, RELAY_FIRST, 1'b0, 1'b0), 1'b1, RES_NONE);
        add_row(make_op(FUNC_REMOVE, ID_MAX, RELAY_FIRST, 1'b0, 1'b0), 1'b1, RES_NONE);
        add_row(make_op(FUNC_ADD, ID_ZERO, RELAY_FIRST, 1'b1, 1'b1), 1'b1, RES_NONE);
        add_row(make_op(FUNC_ADD, ID_MAX, RELAY_ZERO, 1'b1, 1'b0), 1'b1, RES_OK);
        add_row(make_op(FUNC_ADD, ID_ONE, RELAY_TOP, 1'b0, 1'b1), 1'b1, RES_OK);
        add_row(make_op(FUNC_ADD, ID_MAX, RELAY_FIRST, 1'b0, 1'b1), 1'b1, RES_NONE);
        add_row(make_op(FUNC_AUTH, ID_MAX, RELAY_FIRST, 1'b0, 1'b0), 1'b1, RES_OK);
        add_row(make_op(FUNC_AUTH, ID_MAX, RELAY_SECOND, 1'b1, 1'b1), 1'b1, RES_NONE);
        add_row(make_op(FUNC_AUTH, ID_ONE, RELAY_SECOND, 1'b0, 1'b0), 1'b1, RES_OK);
        add_row(make_op(FUNC_AUTH, ID_ONE, RELAY_FIRST, 1'b0, 1'b0), 1'b1, RES_NONE);
        add_row(make_op(FUNC_AUTH, ID_MAX, RELAY_ZERO, 1'b1, 1'b1), 1'b1, RES_NONE);
        add_row(make_op(FUNC_AUTH, ID_MAX, RELAY_TOP, 1'b1, 1'b1), 1'b1, RES_NONE);
        add_row(make_op(FUNC_GET, ID_MAX, RELAY_SECOND, 1'b0, 1'b0), 1'b1, RES_FIRST);
        add_row(make_op(FUNC_GET, ID_ONE, RELAY_FIRST, 1'b1, 1'b1), 1'b0, RES_NONE);
        add_row(make_op(FUNC_AUTH, ID_ZERO, RELAY_FIRST, 1'b1, 1'b1), 1'b1, RES_NONE);
        add_row(make_op(FUNC_GET, ID_ZERO, RELAY_FIRST, 1'b0, 1'b0), 1'b1, RES_NONE);
        add_row(make_op(FUNC_REMOVE, ID_ZERO, RELAY_FIRST, 1'b0, 1'b0), 1'b1, RES_NONE);
        add_row(make_op(FUNC_SPARE_LO, ID_MAX, RELAY_TOP, 1'b1, 1'b1), 1'b1, RES_NONE);
        add_row(make_op(FUNC_SPARE_MID, ID_ONE, RELAY_FIRST, 1'b1, 1'b1), 1'b1, RES_NONE);
        add_row(make_op(FUNC_SPARE_HI, ID_MAX, RELAY_TOP, 1'b1, 1'b1), 1'b1, RES_NONE);
        add_row(make_op(FUNC_REMOVE, ID_ONE, RELAY_FIRST, 1'b0, 1'b0), 1'b1, RES_OK);
        add_row(make_op(FUNC_GET, ID_ONE, RELAY_FIRST, 1'b0, 1'b0), 1'b1, RES_NONE);
        add_row(make_op(FUNC_ADD, ID_MID, RELAY_SECOND, 1'b1, 1'b1), 1'b0, RES_NONE);
        add_row(make_op(FUNC_CLEAR, ID_MID, RELAY_FIRST, 1'b0, 1'b0), 1'b1, RES_OK);
        add_row(make_op(FUNC_GET, ID_MID, RELAY_FIRST, 1'b0, 1'b0), 1'b1, RES_NONE);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            push_op(dir_rows[i].op, dir_rows[i].fixed, dir_rows[i].res);
            pace();
        end

        for (int n = 0; n < 50; n++) begin
            push_op(random_op());
            pace();
        end

        // let everything settle before filling the table
        drain_results();

        push_op(make_op(FUNC_CLEAR, rand_id(), rand_relay(), 1'b1, 1'b1));
        filled_ids.delete();
        while (acl_count < TABLE_ENTRIES) begin
            id = rand_id();
            push_op(make_op(FUNC_ADD, id, rand_relay(), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1))));
            filled_ids.push_back(id);
            if ($urandom_range(0, 31) == 0)
                push_op(make_op(FUNC_GET, filled_ids[$urandom_range(0, filled_ids.size() - 1)],
                                rand_relay(), 1'b0, 1'b0));
            pace();
        end

        // full table: refused adds, then holes opened and refilled
        push_op(make_op(FUNC_ADD, rand_id(), RELAY_FIRST, 1'b1, 1'b1));
        push_op(make_op(FUNC_ADD, filled_ids[0], RELAY_FIRST, 1'b1, 1'b1));
        for (int n = 0; n < 24; n++) begin
            k = $urandom_range(0, filled_ids.size() - 1);
            case ($urandom_range(0, 3))
                0: begin
                    push_op(make_op(FUNC_REMOVE, filled_ids[k], rand_relay(), 1'b0, 1'b0));
                    filled_ids.delete(k);
                end
                1: begin
                    id = rand_id();
                    push_op(make_op(FUNC_ADD, id, rand_relay(), 1'($urandom_range(0, 1)),
                                    1'($urandom_range(0, 1))));
                    filled_ids.push_back(id);
                end
                2: push_op(make_op(FUNC_GET, filled_ids[k], rand_relay(), 1'b0, 1'b0));
                default: push_op(make_op(FUNC_AUTH, filled_ids[k], rand_relay(), 1'b0, 1'b0));
            endcase
            pace();
        end
        push_op(make_op(FUNC_CLEAR, ID_ZERO, RELAY_ZERO, 1'b0, 1'b0));

        for (int n = 0; n < 40; n++) begin
            push_op(random_op());
            pace();
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
